FILE: hw/rtl/q2k_pkg.sv
// Shared types, codes and the fp16 decode helper of the q2k weight dequantizer.
package q2k_pkg;

  localparam logic [1:0] KIND_HDR_LO = 2'd0;
  localparam logic [1:0] KIND_HDR_HI = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;

  localparam int unsigned LANES     = 4;
  localparam int unsigned SCALES    = 16;
  localparam int unsigned FIX_W     = 40;
  localparam int unsigned HI_W      = 46;
  localparam int unsigned LO_W      = 44;
  localparam int unsigned SUM_W     = 48;
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] blk_scale;
    logic [15:0] blk_min;
    logic [63:0] scale_bytes;
    logic [7:0]  data_byte;
    logic [5:0]  byte_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  first_position;
    logic [31:0] value0;
    logic [31:0] value1;
    logic [31:0] value2;
    logic [31:0] value3;
  } out_item_t;

  // One data item as it travels from the front to the back.
  typedef struct packed {
    logic [7:0]       data_byte;
    logic [7:0]       first_position;
    logic [15:0]      scale_h;
    logic [15:0]      min_h;
    logic [3:0][7:0]  sbytes;
  } entry_t;

  typedef struct packed {
    logic [FIX_W-1:0] fix;
    logic             inf;
    logic             nan;
  } half_fix_t;

  // Magnitude of an fp16 value as an integer count of 2^-24 units.
  function automatic half_fix_t half_to_fix(input logic [15:0] h);
    half_fix_t r;
    r.inf = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
    r.nan = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
    if (h[14:10] == 5'd0) begin
      r.fix = FIX_W'(h[9:0]);
    end else begin
      r.fix = FIX_W'({1'b1, h[9:0]}) << (h[14:10] - 5'd1);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/q2k_weight_dequantizer_top.sv
// Top level of the q2k weight dequantizer: front end, queue and fp32 pipeline.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | q2k_pkg::in_item_t
//   out_    | output    | out_valid/out_stall | q2k_pkg::out_item_t
//
// One item is taken every cycle while in_stall is low; headers give no result, data items give one.
// A data result passes through the queue and then the arithmetic stages (multiply,
// add, leading-one search, normalize and round), the last of which loads the output register.
// Reset is synchronous and active low; it clears the scales to zero.
// A stalled output freezes the pipeline; the two-entry queue then fills and
// raises in_stall.
module q2k_weight_dequantizer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  q2k_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output q2k_pkg::out_item_t out_data
);

  logic            q_full, q_push, q_pop, q_valid;
  q2k_pkg::entry_t q_entry, q_head;

  q2k_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_full, .q_push, .q_entry
  );

  q2k_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_entry(q_entry), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .head(q_head)
  );

  q2k_back u_back (
    .clk, .rst_n, .q_valid, .q_head, .q_pop,
    .out_valid, .out_stall, .out_data
  );

endmodule

FILE: hw/rtl/q2k_front.sv
// Front end: holds the block scales, takes headers and queues data items.
module q2k_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  q2k_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output q2k_pkg::entry_t   q_entry
);

  logic [15:0] scale_r;
  logic [15:0] min_r;
  logic [7:0]  sbs_r [q2k_pkg::SCALES];
  logic        accept;
  logic [7:0]  first;
  logic [7:0]  pos;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && (in_data.kind == q2k_pkg::KIND_DATA);

  assign first = in_data.byte_index[5] ? (8'(in_data.byte_index) + 8'd96)
                                       : 8'(in_data.byte_index);

  always_comb begin
    q_entry.data_byte      = in_data.data_byte;
    q_entry.first_position = first;
    q_entry.scale_h        = scale_r;
    q_entry.min_h          = min_r;
    pos                    = first;
    for (int k = 0; k < q2k_pkg::LANES; k++) begin
      pos = first + 8'(32 * k);
      q_entry.sbytes[k] = sbs_r[pos[7:4]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= '0;
      min_r   <= '0;
      for (int i = 0; i < q2k_pkg::SCALES; i++) sbs_r[i] <= '0;
    end else if (accept) begin
      case (in_data.kind)
        q2k_pkg::KIND_HDR_LO: begin
          scale_r <= in_data.blk_scale;
          min_r   <= in_data.blk_min;
          for (int i = 0; i < 8; i++) sbs_r[i] <= in_data.scale_bytes[8*i +: 8];
        end
        q2k_pkg::KIND_HDR_HI: begin
          for (int i = 0; i < 8; i++) sbs_r[8+i] <= in_data.scale_bytes[8*i +: 8];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/q2k_queue.sv
// Two-entry queue that decouples the front end from the arithmetic pipeline.
module q2k_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  q2k_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output q2k_pkg::entry_t head
);

  q2k_pkg::entry_t mem_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: hw/rtl/q2k_back.sv
// Back end: four-lane fixed-point multiply, add, normalize and round to fp32.
module q2k_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  q2k_pkg::entry_t     q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output q2k_pkg::out_item_t  out_data
);

  typedef struct packed {
    logic [q2k_pkg::HI_W-1:0] hi;
    logic [q2k_pkg::LO_W-1:0] lo;
    logic hs, ls, hinf, linf, nan;
  } l1_t;

  typedef struct packed {
    logic [q2k_pkg::SUM_W-1:0] mag;
    logic sgn, zs, inf, isgn, nan;
  } l2_t;

  typedef struct packed {
    logic [q2k_pkg::SUM_W-1:0] mag;
    logic [5:0] lead;
    logic sgn, inf, nan;
  } l3_t;

  logic en;
  logic v1_r, v2_r, v3_r, v4_r;
  logic [7:0] p1_r, p2_r, p3_r;
  l1_t l1_r [q2k_pkg::LANES];
  l1_t l1_nxt [q2k_pkg::LANES];
  l2_t l2_r [q2k_pkg::LANES];
  l2_t l2_nxt [q2k_pkg::LANES];
  l3_t l3_r [q2k_pkg::LANES];
  l3_t l3_nxt [q2k_pkg::LANES];
  logic [31:0] val_nxt [q2k_pkg::LANES];
  q2k_pkg::out_item_t out_r;

  // The whole pipeline advances together whenever the output can move.
  assign en        = !v4_r || !out_stall;
  assign q_pop     = en && q_valid;
  assign out_valid = v4_r;
  assign out_data  = out_r;

  always_comb begin
    q2k_pkg::half_fix_t dsc, dmn;
    logic [7:0] sb;
    logic [3:0] mabs;
    logic [5:0] sc;
    dsc = q2k_pkg::half_to_fix(q_head.scale_h);
    dmn = q2k_pkg::half_to_fix(q_head.min_h);
    for (int k = 0; k < q2k_pkg::LANES; k++) begin
      sb   = q_head.sbytes[k];
      mabs = sb[7] ? (~sb[7:4] + 4'd1) : sb[7:4];
      sc   = 6'(sb[3:0]) * 6'(q_head.data_byte[2*k +: 2]);
      l1_nxt[k].hi   = q2k_pkg::HI_W'(dsc.fix) * q2k_pkg::HI_W'(sc);
      l1_nxt[k].lo   = q2k_pkg::LO_W'(dmn.fix) * q2k_pkg::LO_W'(mabs);
      l1_nxt[k].hs   = q_head.scale_h[15];
      l1_nxt[k].ls   = q_head.min_h[15] ^ sb[7];
      l1_nxt[k].hinf = dsc.inf && (sc != 6'd0);
      l1_nxt[k].linf = dmn.inf && (mabs != 4'd0);
      l1_nxt[k].nan  = dsc.nan || dmn.nan || (dsc.inf && (sc == 6'd0)) ||
                       (dmn.inf && (mabs == 4'd0)) ||
                       (dsc.inf && (sc != 6'd0) && dmn.inf && (mabs != 4'd0) &&
                        (q_head.scale_h[15] != (q_head.min_h[15] ^ sb[7])));
    end
  end

  always_comb begin
    logic [q2k_pkg::SUM_W-1:0] h, l;
    for (int k = 0; k < q2k_pkg::LANES; k++) begin
      h = q2k_pkg::SUM_W'(l1_r[k].hi);
      l = q2k_pkg::SUM_W'(l1_r[k].lo);
      if (l1_r[k].hs == l1_r[k].ls) begin
        l2_nxt[k].mag = h + l;
        l2_nxt[k].sgn = l1_r[k].hs;
      end else if (h >= l) begin
        l2_nxt[k].mag = h - l;
        l2_nxt[k].sgn = l1_r[k].hs;
      end else begin
        l2_nxt[k].mag = l - h;
        l2_nxt[k].sgn = l1_r[k].ls;
      end
      // An exact zero is negative only when both terms are negative zeros.
      l2_nxt[k].zs   = l1_r[k].hs && l1_r[k].ls;
      l2_nxt[k].inf  = l1_r[k].hinf || l1_r[k].linf;
      l2_nxt[k].isgn = l1_r[k].hinf ? l1_r[k].hs : l1_r[k].ls;
      l2_nxt[k].nan  = l1_r[k].nan;
    end
  end

  always_comb begin
    for (int k = 0; k < q2k_pkg::LANES; k++) begin
      l3_nxt[k].mag  = l2_r[k].mag;
      l3_nxt[k].lead = 6'd0;
      for (int i = 0; i < q2k_pkg::SUM_W; i++) begin
        if (l2_r[k].mag[i]) l3_nxt[k].lead = 6'(i);
      end
      l3_nxt[k].inf = l2_r[k].inf;
      l3_nxt[k].nan = l2_r[k].nan;
      if (l2_r[k].inf) begin
        l3_nxt[k].sgn = l2_r[k].isgn;
      end else if (l2_r[k].mag == '0) begin
        l3_nxt[k].sgn = l2_r[k].zs;
      end else begin
        l3_nxt[k].sgn = l2_r[k].sgn;
      end
    end
  end

  always_comb begin
    logic [q2k_pkg::SUM_W-1:0] norm;
    logic [7:0]  ex;
    logic        inc;
    logic [30:0] pack;
    for (int k = 0; k < q2k_pkg::LANES; k++) begin
      norm = l3_r[k].mag << (6'd47 - l3_r[k].lead);
      ex   = 8'(l3_r[k].lead) + 8'd103;
      inc  = norm[23] && ((norm[22:0] != 23'd0) || norm[24]);
      pack = {ex, norm[46:24]} + 31'(inc);
      if (l3_r[k].nan) begin
        val_nxt[k] = q2k_pkg::CANON_NAN;
      end else if (l3_r[k].inf) begin
        val_nxt[k] = {l3_r[k].sgn, 31'd0} | q2k_pkg::INF_BITS;
      end else if (l3_r[k].mag == '0) begin
        val_nxt[k] = {l3_r[k].sgn, 31'd0};
      end else begin
        val_nxt[k] = {l3_r[k].sgn, pack};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= q_head.first_position;
      p2_r <= p1_r;
      p3_r <= p2_r;
      for (int k = 0; k < q2k_pkg::LANES; k++) begin
        l1_r[k] <= l1_nxt[k];
        l2_r[k] <= l2_nxt[k];
        l3_r[k] <= l3_nxt[k];
      end
      out_r.first_position <= p3_r;
      out_r.value0 <= val_nxt[0];
      out_r.value1 <= val_nxt[1];
      out_r.value2 <= val_nxt[2];
      out_r.value3 <= val_nxt[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= q_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

endmodule

FILE: hw/rtl/q2k_checker.sv
// Port-level checks of the q2k weight dequantizer and their bind.
module q2k_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input q2k_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input q2k_pkg::out_item_t out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input transaction changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.first_position[6:5] == 2'd0))
    else $error("first position outside both half spans");

  a_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.value0[30:23] == 8'hFF) && (out_data.value0[22:0] != 23'd0)
    |-> out_data.value0 == q2k_pkg::CANON_NAN)
    else $error("non-canonical NaN");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("activity right after reset");

endmodule

bind q2k_weight_dequantizer_top q2k_checker u_checker (.*);

FILE: sim/tb.sv
// Self-checking testbench of the q2k weight dequantizer with a built-in fp32 predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 300000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  q2k_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  q2k_pkg::out_item_t out_data;

  q2k_weight_dequantizer_top dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  // Predictor state: a copy of the block's scales.
  logic [15:0] pred_scale_h;
  logic [15:0] pred_min_h;
  logic [7:0]  pred_sub_scales [q2k_pkg::SCALES];

  q2k_pkg::in_item_t  pending_items [$];
  q2k_pkg::out_item_t expected_weights [$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned tx_idle;
  int unsigned rx_idle;
  int unsigned hold_left;
  bit hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  // Rounds a nonzero magnitude in 2^-24 units to fp32, nearest even.
  function automatic logic [31:0] units_to_fp32(input bit sgn, input longint unsigned mag);
    int e;
    int sh;
    longint unsigned keep;
    longint unsigned rem;
    longint unsigned half;
    e = 0;
    for (int i = 0; i < 64; i++) if (mag[i]) e = i;
    if (e <= 23) begin
      keep = mag << (23 - e);
    end else begin
      sh = e - 23;
      keep = mag >> sh;
      rem = mag & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep++;
      if (keep[24]) begin
        keep = keep >> 1;
        e++;
      end
    end
    return {sgn, 8'(e + 103), keep[22:0]};
  endfunction

  function automatic longint unsigned half_units(input logic [15:0] h);
    if (h[14:10] == 5'd0) return longint'(h[9:0]);
    return longint'({1'b1, h[9:0]}) << (h[14:10] - 1);
  endfunction

  function automatic logic [31:0] weight_value(input logic [7:0] sb, input logic [1:0] q,
                                               input logic [15:0] hs, input logic [15:0] hm);
    int s;
    int m;
    bit s_inf, s_nan, m_inf, m_nan, lo_neg, hi_neg;
    longint unsigned lo_mag, hi_mag;
    longint sum;
    s = sb[3:0];
    m = sb[7] ? int'(sb[7:4]) - 16 : int'(sb[7:4]);
    s_inf = hs[14:10] == 5'h1F && hs[9:0] == 0;
    s_nan = hs[14:10] == 5'h1F && hs[9:0] != 0;
    m_inf = hm[14:10] == 5'h1F && hm[9:0] == 0;
    m_nan = hm[14:10] == 5'h1F && hm[9:0] != 0;
    lo_neg = hm[15] ^ (m < 0);
    hi_neg = hs[15];
    if (s_nan || m_nan) return q2k_pkg::CANON_NAN;
    // Infinity times zero is NaN.
    if (s_inf && s * q == 0) return q2k_pkg::CANON_NAN;
    if (m_inf && m == 0) return q2k_pkg::CANON_NAN;
    if (s_inf && m_inf && lo_neg != hi_neg) return q2k_pkg::CANON_NAN;
    if (m_inf) return {lo_neg, q2k_pkg::INF_BITS[30:0]};
    if (s_inf) return {hi_neg, q2k_pkg::INF_BITS[30:0]};
    lo_mag = half_units(hm) * longint'(m < 0 ? -m : m);
    hi_mag = half_units(hs) * longint'(s * q);
    sum = (lo_neg ? -longint'(lo_mag) : longint'(lo_mag))
        + (hi_neg ? -longint'(hi_mag) : longint'(hi_mag));
    if (sum == 0) begin
      // Only two negative zeros add up to a negative zero.
      return {(lo_mag == 0 && lo_neg && hi_mag == 0 && hi_neg), 31'd0};
    end
    return units_to_fp32(sum < 0, sum < 0 ? -sum : sum);
  endfunction

  task automatic predict_weights(input q2k_pkg::in_item_t it);
    q2k_pkg::out_item_t r;
    logic [7:0] first;
    logic [7:0] pos;
    logic [31:0] v [q2k_pkg::LANES];
    case (it.kind)
      q2k_pkg::KIND_HDR_LO, q2k_pkg::KIND_HDR_HI: begin
        if (it.kind == q2k_pkg::KIND_HDR_LO) begin
          pred_scale_h = it.blk_scale;
          pred_min_h = it.blk_min;
        end
        for (int k = 0; k < 8; k++)
          pred_sub_scales[(it.kind == q2k_pkg::KIND_HDR_HI ? 8 : 0) + k] =
            it.scale_bytes[8*k +: 8];
      end
      q2k_pkg::KIND_DATA: begin
        first = it.byte_index < 32 ? 8'(it.byte_index) : 8'(it.byte_index) + 8'd96;
        for (int k = 0; k < q2k_pkg::LANES; k++) begin
          pos = first + 8'(32 * k);
          v[k] = weight_value(pred_sub_scales[pos[7:4]], it.data_byte[2*k +: 2],
                              pred_scale_h, pred_min_h);
        end
        r = '{first, v[0], v[1], v[2], v[3]};
        expected_weights.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic push_header(input logic [15:0] hs, input logic [15:0] hm,
                             input logic [63:0] lo, input logic [63:0] hi);
    pending_items.push_back('{q2k_pkg::KIND_HDR_LO, hs, hm, lo, 8'($urandom), 6'($urandom)});
    pending_items.push_back('{q2k_pkg::KIND_HDR_HI, 16'($urandom), 16'($urandom), hi,
                              8'($urandom), 6'($urandom)});
  endtask

  task automatic push_data(input logic [7:0] b, input logic [5:0] idx);
    pending_items.push_back('{q2k_pkg::KIND_DATA, 16'($urandom), 16'($urandom),
                              {$urandom, $urandom}, b, idx});
  endtask

  function automatic logic [15:0] pick_half();
    case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h0001;
      3: return 16'h83FF;
      4: return 16'h7C00;
      5: return 16'hFC00;
      6: return 16'h7E01;
      7: return 16'hFBFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic fill_random(input int unsigned target);
    int unsigned n;
    int unsigned len;
    n = 0;
    while (n < target) begin
      if ($urandom_range(0, 99) < 8) begin
        pending_items.push_back('{2'($urandom), 16'($urandom), 16'($urandom),
                                  {$urandom, $urandom}, 8'($urandom), 6'($urandom)});
        n++;
      end else begin
        push_header(pick_half(), pick_half(), {$urandom, $urandom}, {$urandom, $urandom});
        len = $urandom_range(4, 20);
        for (int i = 0; i < len; i++) push_data(8'($urandom), 6'($urandom));
        n += len + 2;
      end
    end
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_weights.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  // Sender: a transaction is taken at a rising edge; the next one is offered at the falling edge.
  bit in_taken;
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      predict_weights(in_data);
      items_sent++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
        in_valid <= 1'b1;
        in_data <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off so the block backs up into its input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left == 0 && !hold_done && cycles >= 400) begin
        hold_left = 150;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= $urandom_range(0, 99) < rx_idle;
      end
    end
  end

  always @(posedge clk) begin
    q2k_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_weights.size() == 0) begin
        report("unexpected result", out_data.value0, 32'd0);
      end else begin
        want = expected_weights.pop_front();
        if (out_data.first_position != want.first_position)
          report("first_position", 32'(out_data.first_position), 32'(want.first_position));
        if (out_data.value0 != want.value0) report("value0", out_data.value0, want.value0);
        if (out_data.value1 != want.value1) report("value1", out_data.value1, want.value1);
        if (out_data.value2 != want.value2) report("value2", out_data.value2, want.value2);
        if (out_data.value3 != want.value3) report("value3", out_data.value3, want.value3);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    tx_idle = 26;
    rx_idle = 70;
    pred_scale_h = '0;
    pred_min_h = '0;
    for (int i = 0; i < q2k_pkg::SCALES; i++) pred_sub_scales[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Data before any header uses the zero state.
    push_data(8'hFF, 6'd0);
    push_data(8'h00, 6'd63);
    push_header(16'h3C00, 16'hBC00, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000);
    push_data(8'hE4, 6'd31);
    push_data(8'hFF, 6'd32);
    push_data(8'h1B, 6'd63);
    // Kind three is dropped without any effect.
    pending_items.push_back('{KIND_NONE, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                              8'hFF, 6'd63});
    push_data(8'hAA, 6'd5);
    push_header(16'h7BFF, 16'h7BFF, 64'h8F7F_0F80_F18F_7117, 64'h08F0_88FF_7799_1234);
    push_data(8'hFF, 6'd0);
    push_data(8'h55, 6'd40);
    push_header(16'h0001, 16'h8001, 64'h9F3C_A5F1_8F8F_0F0F, 64'hF0E1_D2C3_B4A5_9687);
    push_data(8'hFF, 6'd12);
    push_header(16'h7C00, 16'hFC00, 64'h0F10_8F01_F0FF_1F00, 64'h0180_0F70_FFF0_8101);
    push_data(8'hE4, 6'd16);
    push_data(8'h00, 6'd48);
    push_header(16'h7E00, 16'h3C00, 64'h1111_1111_1111_1111, 64'h1111_1111_1111_1111);
    push_data(8'h39, 6'd20);

    fill_random(520);
    drain();
    tx_idle = 70;
    rx_idle = 26;
    fill_random(540);
    drain();
    tx_idle = 0;
    rx_idle = 0;
    fill_random(540);
    drain();
    repeat (20) @(posedge clk);

    $display("%0d input transactions accepted, %0d results checked over three idle patterns",
             items_sent, results_seen);
    $display("included fp16 extremes, infinities, NaNs and a long output hold-off");
    if (errors == 0 && expected_weights.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_weights.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/q2k_pkg.sv
hw/rtl/q2k_front.sv
hw/rtl/q2k_queue.sv
hw/rtl/q2k_back.sv
hw/rtl/q2k_weight_dequantizer_top.sv
hw/rtl/q2k_checker.sv
sim/tb.sv
